/* src/sftc_pkg.sv */
// ----------------------------------------------------------------------------
// sftc_pkg
// Shared constants, types and the fractional power-of-two table for the
// softmax threshold classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package sftc_pkg;

	localparam int MAX_CLASSES = 1024;
	localparam int ADDR_W      = $clog2(MAX_CLASSES);
	localparam int CNT_W       = $clog2(MAX_CLASSES + 1);
	localparam int RESULT_CAP  = 50;
	localparam int RES_W       = $clog2(RESULT_CAP + 1);

	localparam int LOGIT_W = 16;
	localparam int IDX_W   = 10;
	localparam int CONF_W  = 14;
	localparam int EXP_W   = 32;
	localparam int SUM_W   = 40;
	localparam int PROD_W  = EXP_W + CONF_W;   // exp * 10000
	localparam int TSUM_W  = SUM_W + CONF_W;   // threshold * sum
	localparam int MANT_W  = 18;

	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 32;
	localparam logic [CFG_AW-1:0] REG_THRESHOLD = 3'd0;

	localparam logic [CONF_W-1:0] THRESH_RESET = 14'd5100;
	localparam logic [CONF_W-1:0] THRESH_FLOOR = 14'd200;
	localparam logic [CONF_W-1:0] CONF_FULL    = 14'd10000;
	localparam logic signed [13:0] LOG2E_Q12   = 14'sd5909;

	// one exponential leaving the exp pipeline
	typedef struct packed {
		logic             valid;
		logic             last;
		logic [EXP_W-1:0] value;
	} exp_res_t;

	// round(2^(i/16) * 65536)
	function automatic logic [MANT_W-1:0] pow2_frac(input logic [4:0] i);
		logic [MANT_W-1:0] v;
		case (i)
			5'd0:  v = 18'd65536;
			5'd1:  v = 18'd68438;
			5'd2:  v = 18'd71468;
			5'd3:  v = 18'd74632;
			5'd4:  v = 18'd77936;
			5'd5:  v = 18'd81386;
			5'd6:  v = 18'd84990;
			5'd7:  v = 18'd88752;
			5'd8:  v = 18'd92682;
			5'd9:  v = 18'd96785;
			5'd10: v = 18'd101070;
			5'd11: v = 18'd105545;
			5'd12: v = 18'd110218;
			5'd13: v = 18'd115098;
			5'd14: v = 18'd120194;
			5'd15: v = 18'd125515;
			default: v = 18'd131072;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* src/sftc_if.sv */
// ----------------------------------------------------------------------------
// sftc_if
// Valid/ready channels for logit items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface sftc_logit_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sftc_pkg::LOGIT_W-1:0] logit;
	logic                                 last_logit;

	modport source (output valid, output logit, output last_logit, input ready);
	modport sink   (input valid, input logit, input last_logit, output ready);
endinterface

interface sftc_result_if;
	logic                          valid;
	logic                          ready;
	logic [sftc_pkg::IDX_W-1:0]    class_index;
	logic [sftc_pkg::CONF_W-1:0]   confidence;
	logic                          found;
	logic                          last_result;

	modport source (output valid, output class_index, output confidence, output found,
		output last_result, input ready);
	modport sink   (input valid, input class_index, input confidence, input found,
		input last_result, output ready);
endinterface

`default_nettype wire

/* src/sftc_exp.sv */
// ----------------------------------------------------------------------------
// sftc_exp
// Two-stage fixed-point exponential: log2(e) scaling, then table,
// interpolation and shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sftc_exp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic signed [sftc_pkg::LOGIT_W-1:0] in_logit,
	input  wire logic                                 in_last,
	output sftc_pkg::exp_res_t                        res_s2,
	output logic                                      last_busy
);

	logic               v_s1;
	logic               last_s1;
	logic signed [17:0] y_s1;
	logic signed [29:0] prod;

	logic                        v_s2;
	logic                        last_s2;
	logic [sftc_pkg::EXP_W-1:0]  value_s2;

	logic signed [9:0]               ip;
	logic [3:0]                      idx;
	logic [3:0]                      lo;
	logic [sftc_pkg::MANT_W-1:0]     t0;
	logic [sftc_pkg::MANT_W-1:0]     t1;
	logic [16:0]                     step;
	logic [sftc_pkg::MANT_W-1:0]     mant;
	logic [9:0]                      nip;
	logic [33:0]                     shl;
	logic [sftc_pkg::EXP_W-1:0]      e;

	// scale by log2(e) in Q12, keep Q8
	assign prod = in_logit * sftc_pkg::LOG2E_Q12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		y_s1    <= prod[29:12];
		last_s1 <= in_last;
	end

	// mantissa from table with linear interpolation, then shift by integer part
	always_comb begin
		ip   = y_s1[17:8];
		idx  = y_s1[7:4];
		lo   = y_s1[3:0];
		t0   = sftc_pkg::pow2_frac({1'b0, idx});
		t1   = sftc_pkg::pow2_frac({1'b0, idx} + 5'd1);
		step = 17'((t1 - t0) * {14'd0, lo});
		mant = t0 + {5'd0, step[16:4]};
		nip  = -ip;
		shl  = {16'd0, mant} << ip[3:0];
		if (ip >= 10'sd16) begin
			e = '1;
		end else if (ip >= 10'sd0) begin
			e = shl[31:0];
		end else if (ip <= -10'sd32) begin
			e = '0;
		end else begin
			e = {14'd0, mant} >> nip[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s2  <= last_s1;
		value_s2 <= e;
	end

	assign res_s2    = '{valid: v_s2, last: last_s2, value: value_s2};
	assign last_busy = (v_s1 && last_s1) || (v_s2 && last_s2);

endmodule

`default_nettype wire

/* src/sftc_div.sv */
// ----------------------------------------------------------------------------
// sftc_div
// Restoring divider, one quotient bit a cycle, for the confidence value.
// ----------------------------------------------------------------------------
`default_nettype none

module sftc_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [sftc_pkg::PROD_W-1:0]       dividend,
	input  wire logic [sftc_pkg::SUM_W-1:0]        divisor,
	output logic                                   busy,
	output logic                                   done,
	output logic [sftc_pkg::CONF_W-1:0]            quotient
);

	logic [sftc_pkg::PROD_W-1:0] rem_q;
	logic [sftc_pkg::TSUM_W-1:0] dsh_q;
	logic [sftc_pkg::CONF_W-1:0] q_q;
	logic [3:0]                  cnt_q;
	logic                        ge;

	assign ge = {{(sftc_pkg::TSUM_W - sftc_pkg::PROD_W){1'b0}}, rem_q} >= dsh_q;

	// advance one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy  <= 1'b1;
				cnt_q <= 4'(sftc_pkg::CONF_W - 1);
			end else if (busy) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= {divisor, {(sftc_pkg::CONF_W - 1){1'b0}}, 1'b0} >> 1;
			q_q   <= '0;
		end else if (busy) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[sftc_pkg::PROD_W-1:0];
			end
			q_q   <= {q_q[sftc_pkg::CONF_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	// clamp to full scale
	assign quotient = (q_q > sftc_pkg::CONF_FULL) ? sftc_pkg::CONF_FULL : q_q;

endmodule

`default_nettype wire

/* src/softmax_threshold_classifier.sv */
// ----------------------------------------------------------------------------
// softmax_threshold_classifier
// Softmax over one frame of Q8.8 logits with a confidence threshold.
//
// Usage: logits enter on the logits channel, one class per item, in class
// order; last_logit marks the end of the frame. Each logit becomes a
// fixed-point exponential that is written to a 1024-entry memory and added
// to a saturating 40-bit sum. Logits are taken one per cycle while a frame
// loads. After the marked item the input is held off while the block walks
// the memory one class per cycle, comparing exp*10000 against threshold*sum;
// each passing class pauses the walk and runs the restoring divider for its
// confidence. Results leave on the results channel in class order, the
// final one marked; with no passing class a single item with found clear is
// sent. At most 50 results per frame. Reset clears the sum and counters and
// sets the threshold to 5100; the memory needs no clearing. A stalled
// receiver holds the output register and pauses the walk.
// ----------------------------------------------------------------------------
`default_nettype none

module softmax_threshold_classifier (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	sftc_logit_if.sink                          logits,
	sftc_result_if.source                       results,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [sftc_pkg::CFG_AW-1:0]    paddr,
	input  wire logic [sftc_pkg::CFG_DW-1:0]    pwdata,
	output logic [sftc_pkg::CFG_DW-1:0]         prdata,
	output logic                                pready
);

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_WALK = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_PUSH = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]                    state_q;
	logic [sftc_pkg::CONF_W-1:0]   thr_q;
	logic [sftc_pkg::CONF_W-1:0]   thr_eff;
	logic [sftc_pkg::SUM_W-1:0]    sum_q;
	logic [sftc_pkg::CNT_W-1:0]    cnt_q;
	logic [sftc_pkg::SUM_W:0]      sum_add;
	logic [sftc_pkg::TSUM_W-1:0]   thr_sum_q;

	sftc_pkg::exp_res_t            exp_s2;
	logic                          last_busy;
	logic                          store_ok;

	logic [sftc_pkg::EXP_W-1:0]    mem [sftc_pkg::MAX_CLASSES];
	logic [sftc_pkg::EXP_W-1:0]    rdata_q;
	logic [sftc_pkg::CNT_W-1:0]    i_q;
	logic                          issue;
	logic                          rv_s1;
	logic [sftc_pkg::CNT_W-1:0]    ridx_s1;
	logic                          pv_s2;
	logic [sftc_pkg::CNT_W-1:0]    pidx_s2;
	logic [sftc_pkg::PROD_W-1:0]   prod_s2;
	logic                          pass;

	logic                          div_busy;
	logic                          div_done;
	logic [sftc_pkg::CONF_W-1:0]   div_q;
	logic [sftc_pkg::CNT_W-1:0]    hit_q;

	logic                          pend_v_q;
	logic [sftc_pkg::CNT_W-1:0]    pend_idx_q;
	logic [sftc_pkg::CONF_W-1:0]   pend_conf_q;
	logic [sftc_pkg::RES_W-1:0]    n_q;

	logic                          out_v_q;
	logic                          out_free;
	logic                          out_load;
	logic                          push_go;
	logic                          cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (paddr[sftc_pkg::CFG_AW-1:2] == sftc_pkg::REG_THRESHOLD[2]);
	assign prdata = (paddr[sftc_pkg::CFG_AW-1:2] == sftc_pkg::REG_THRESHOLD[2])
		? {{(sftc_pkg::CFG_DW - sftc_pkg::CONF_W){1'b0}}, thr_q} : '0;
	assign thr_eff = (thr_q < sftc_pkg::THRESH_FLOOR) ? sftc_pkg::THRESH_FLOOR : thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= sftc_pkg::THRESH_RESET;
		end else if (cfg_wr) begin
			thr_q <= pwdata[sftc_pkg::CONF_W-1:0];
		end
	end

	// exponential pipeline
	assign logits.ready = (state_q == ST_LOAD) && !last_busy;

	sftc_exp u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (logits.valid && logits.ready),
		.in_logit  (logits.logit),
		.in_last   (logits.last_logit),
		.res_s2    (exp_s2),
		.last_busy (last_busy)
	);

	assign store_ok = exp_s2.valid && (cnt_q < sftc_pkg::CNT_W'(sftc_pkg::MAX_CLASSES));
	assign sum_add  = {1'b0, sum_q} + {{(sftc_pkg::SUM_W + 1 - sftc_pkg::EXP_W){1'b0}},
		exp_s2.value};

	// exponential store: write while loading, read while walking
	always_ff @(posedge clk) begin
		if (store_ok) begin
			mem[cnt_q[sftc_pkg::ADDR_W-1:0]] <= exp_s2.value;
		end
		rdata_q <= mem[i_q[sftc_pkg::ADDR_W-1:0]];
	end

	// walk: issue one read per cycle while no class passes, multiply, then compare
	assign issue = (state_q == ST_WALK) && !pass && (i_q < cnt_q);
	assign pass  = pv_s2 && (state_q == ST_WALK) && (sum_q != '0)
		&& ({{(sftc_pkg::TSUM_W - sftc_pkg::PROD_W){1'b0}}, prod_s2} >= thr_sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
			pv_s2 <= 1'b0;
		end else begin
			rv_s1 <= issue;
			pv_s2 <= rv_s1 && (state_q == ST_WALK) && !pass;
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= i_q;
		pidx_s2 <= ridx_s1;
		prod_s2 <= rdata_q * sftc_pkg::CONF_FULL;
		if (state_q == ST_PREP) begin
			thr_sum_q <= thr_eff * sum_q;
		end
		if (pass) begin
			hit_q <= pidx_s2;
		end
	end

	sftc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pass),
		.dividend (prod_s2),
		.divisor  (sum_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	assign out_free = !out_v_q || results.ready;
	assign push_go  = !pend_v_q || out_free;
	assign out_load = ((state_q == ST_PUSH) && push_go && pend_v_q)
		|| ((state_q == ST_FIN) && out_free);

	// output register valid: load a new item or drop the accepted one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// frame sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			sum_q    <= '0;
			cnt_q    <= '0;
			i_q      <= '0;
			pend_v_q <= 1'b0;
			n_q      <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (store_ok) begin
						cnt_q <= cnt_q + 1'b1;
						sum_q <= sum_add[sftc_pkg::SUM_W] ? '1 : sum_add[sftc_pkg::SUM_W-1:0];
					end
					if (exp_s2.valid && exp_s2.last) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					i_q     <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (pass) begin
						i_q     <= pidx_s2 + 1'b1;
						state_q <= ST_DIV;
					end else if (issue) begin
						i_q <= i_q + 1'b1;
					end else if (!rv_s1 && !pv_s2) begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_go) begin
						pend_v_q <= 1'b1;
						n_q      <= n_q + 1'b1;
						state_q  <= (n_q == sftc_pkg::RES_W'(sftc_pkg::RESULT_CAP - 1))
							? ST_FIN : ST_WALK;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						n_q      <= '0;
						sum_q    <= '0;
						cnt_q    <= '0;
						state_q  <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// hold pending result and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && push_go) begin
			pend_idx_q  <= hit_q;
			pend_conf_q <= div_q;
			if (pend_v_q) begin
				results.class_index <= sftc_pkg::IDX_W'(pend_idx_q);
				results.confidence  <= pend_conf_q;
				results.found       <= 1'b1;
				results.last_result <= 1'b0;
			end
		end else if (state_q == ST_FIN && out_free) begin
			results.class_index <= pend_v_q ? sftc_pkg::IDX_W'(pend_idx_q) : '0;
			results.confidence  <= pend_v_q ? pend_conf_q : '0;
			results.found       <= pend_v_q;
			results.last_result <= 1'b1;
		end
	end

	assign results.valid = out_v_q;

	// the input is held off whenever a frame is being walked
	a_ready_load: assert property (@(posedge clk) disable iff (!arst_n)
		logits.ready |-> state_q == ST_LOAD)
		else $error("input ready outside load phase");

	// result count never passes the cap
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= sftc_pkg::RES_W'(sftc_pkg::RESULT_CAP))
		else $error("result count above cap");

	// divider runs only while the sequencer waits for it
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_DIV)
		else $error("divider busy outside divide state");

	// a passing class stops the walk and starts a divide
	a_pass_div: assert property (@(posedge clk) disable iff (!arst_n)
		pass |=> (state_q == ST_DIV && div_busy && !rv_s1))
		else $error("pass did not start divide");

	// the sum, class count and pending flag are cleared whenever a new frame starts loading
	a_fin_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (sum_q == '0 && cnt_q == '0 && !pend_v_q))
		else $error("frame state not cleared");

endmodule

`default_nettype wire
